/* rtl/core/sks_pkg.sv */
`timescale 1ns / 1ps

package sks_pkg;

  // Field widths of one record.
  localparam int KEY_W = 31;
  localparam int TAG_W = 16;

  // Default number of records that one batch may hold.
  localparam int CAPACITY_DEF = 64;

  // Controller states.
  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic insert;
    logic shift_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_one;
  } status_t;

endpackage

/* rtl/core/sks_ctrl.sv */
`timescale 1ns / 1ps

module sks_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_batch_end,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output sks_pkg::cmd_t   cmd,
  input  sks_pkg::status_t status
);

  sks_pkg::state_t state_r;
  sks_pkg::state_t state_nxt;
  logic in_beat;
  logic out_beat;

  assign in_beat  = in_valid & in_ready;
  assign out_beat = out_valid & out_ready;

  // Next state: a closing input beat starts the drain, the final output beat ends it.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sks_pkg::ST_LOAD: begin
        if (in_beat && in_batch_end) begin
          state_nxt = sks_pkg::ST_EMIT;
        end
      end
      sks_pkg::ST_EMIT: begin
        if (out_beat && status.last_one) begin
          state_nxt = sks_pkg::ST_LOAD;
        end
      end
      default: state_nxt = sks_pkg::ST_LOAD;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sks_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Outputs: handshake and datapath commands.
  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    unique case (state_r)
      sks_pkg::ST_LOAD: in_ready  = 1'b1;
      sks_pkg::ST_EMIT: out_valid = 1'b1;
      default: ;
    endcase
    cmd.insert    = in_valid & in_ready;
    cmd.shift_out = out_valid & out_ready;
  end

  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("input and output sides open together");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && in_batch_end) |=> out_valid)
    else $error("closing beat did not start the drain");
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (out_beat && status.last_one) |=> in_ready)
    else $error("final beat did not return to loading");

endmodule

/* rtl/core/sks_datapath.sv */
`timescale 1ns / 1ps

module sks_datapath #(
  parameter int CAPACITY = sks_pkg::CAPACITY_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sks_pkg::cmd_t           cmd,
  output sks_pkg::status_t        status,
  input  logic [sks_pkg::KEY_W-1:0] in_key,
  input  logic [sks_pkg::TAG_W-1:0] in_tag,
  output logic [sks_pkg::KEY_W-1:0] out_sorted_key,
  output logic [sks_pkg::TAG_W-1:0] out_sorted_tag,
  output logic                    out_final_result,
  output logic                    out_dropped
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [sks_pkg::KEY_W-1:0] key_r [CAPACITY];
  logic [sks_pkg::TAG_W-1:0] tag_r [CAPACITY];
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] fill_nxt;
  logic             overflow_r;
  logic             overflow_nxt;
  logic             full;
  logic             ins_en;
  logic [CAPACITY-1:0] greater;

  assign full   = (fill_r == CNT_W'(CAPACITY));
  assign ins_en = cmd.insert & ~full;
  assign status.last_one = (fill_r == CNT_W'(1));

  // Each cell flags whether the new key must go below it; empty cells count as greater,
  // so the new record lands just after the last stored key that is not larger.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      greater[i] = (CNT_W'(i) < fill_r) ? (key_r[i] > in_key) : 1'b1;
    end
  end

  // Insertion chain: cells above the slot shift up, the slot takes the new record.
  // On an output beat every cell but the last takes the record of the cell above it.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic take_new;
    if (g == 0) begin : g_first
      assign take_new = 1'b1;
    end else begin : g_rest
      assign take_new = ~greater[g-1];
    end

    always_ff @(posedge clk) begin
      if (ins_en && greater[g]) begin
        if (take_new) begin
          key_r[g] <= in_key;
          tag_r[g] <= in_tag;
        end else if (g > 0) begin
          key_r[g] <= key_r[(g > 0) ? g - 1 : 0];
          tag_r[g] <= tag_r[(g > 0) ? g - 1 : 0];
        end
      end else if (cmd.shift_out && (g < CAPACITY - 1)) begin
        key_r[g] <= key_r[(g < CAPACITY - 1) ? g + 1 : g];
        tag_r[g] <= tag_r[(g < CAPACITY - 1) ? g + 1 : g];
      end
    end
  end

  // Fill count and overflow flag.
  always_comb begin
    fill_nxt     = fill_r;
    overflow_nxt = overflow_r;
    priority if (cmd.shift_out) begin
      fill_nxt = fill_r - CNT_W'(1);
      if (status.last_one) begin
        overflow_nxt = 1'b0;
      end
    end else if (cmd.insert) begin
      if (full) begin
        overflow_nxt = 1'b1;
      end else begin
        fill_nxt = fill_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      overflow_r <= 1'b0;
    end else begin
      fill_r     <= fill_nxt;
      overflow_r <= overflow_nxt;
    end
  end

  // The head cell is the current output beat.
  assign out_sorted_key   = key_r[0];
  assign out_sorted_tag   = tag_r[0];
  assign out_final_result = status.last_one;
  assign out_dropped      = overflow_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");
  a_drain_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.shift_out && status.last_one) |=> (fill_r == '0 && !overflow_r))
    else $error("store not cleared after the final beat");
  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.insert && full && !cmd.shift_out) |=> (overflow_r && full))
    else $error("record offered to a full store not flagged");

endmodule

/* rtl/core/stable_key_sorter_top.sv */
`timescale 1ns / 1ps

// Stable insertion sorter for batches of up to CAPACITY records. While loading, one
// record is accepted every cycle and slotted at once into a shifting chain of cells,
// after any stored record with an equal key. The beat marked batch_end closes the
// batch: input is then held off while the batch drains in ascending key order, one
// result per cycle from the head of the chain while the receiver is ready. The next
// batch may start in the cycle after the final result. Records offered to a full
// store are discarded and dropped is raised on every result of that batch;
// final_result marks its last result.

module stable_key_sorter_top #(
  parameter int CAPACITY = sks_pkg::CAPACITY_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [sks_pkg::KEY_W-1:0] in_key,
  input  logic [sks_pkg::TAG_W-1:0] in_tag,
  input  logic                      in_batch_end,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [sks_pkg::KEY_W-1:0] out_sorted_key,
  output logic [sks_pkg::TAG_W-1:0] out_sorted_tag,
  output logic                      out_final_result,
  output logic                      out_dropped
);

  sks_pkg::cmd_t    cmd;
  sks_pkg::status_t status;

  // Sequencing of loading and draining.
  sks_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_batch_end (in_batch_end),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cmd          (cmd),
    .status       (status)
  );

  // Sorted store and batch bookkeeping.
  sks_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_key           (in_key),
    .in_tag           (in_tag),
    .out_sorted_key   (out_sorted_key),
    .out_sorted_tag   (out_sorted_tag),
    .out_final_result (out_final_result),
    .out_dropped      (out_dropped)
  );

endmodule

/* tb/tb_stable_key_sorter_top.sv */
`timescale 1ns / 1ps

module tb_stable_key_sorter_top;

  localparam int KEY_W      = sks_pkg::KEY_W;
  localparam int TAG_W      = sks_pkg::TAG_W;
  localparam int CAPACITY   = sks_pkg::CAPACITY_DEF;
  localparam int RAND_ITEMS = 400;
  localparam int LONG_HOLD  = 300;
  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
  localparam logic [TAG_W-1:0] TAG_MAX = {TAG_W{1'b1}};

  // One sorted beat as the block should present it.
  typedef struct {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             last;
    logic             dropped;
  } sorted_rec_t;

  // Keeps its own sorted copy of the open batch and the beats still owed by the block.
  class batch_sort_model;
    logic [KEY_W-1:0] keys[$];
    logic [TAG_W-1:0] tags[$];
    bit               overflow;
    sorted_rec_t      sorted_due[$];
    int               errors;
    int               records_in;
    int               results_out;
    int               batches;
    int               overflow_batches;

    // Inserts an accepted record after every stored record with an equal key.
    function void load_record(logic [KEY_W-1:0] k, logic [TAG_W-1:0] t, logic e);
      int          pos;
      sorted_rec_t rec;
      records_in++;
      if (keys.size() >= CAPACITY) begin
        overflow = 1'b1;
      end else begin
        pos = keys.size();
        while (pos > 0 && keys[pos-1] > k) pos--;
        keys.insert(pos, k);
        tags.insert(pos, t);
      end
      // The closing record releases the whole batch in ascending order.
      if (e) begin
        foreach (keys[i]) begin
          rec.key     = keys[i];
          rec.tag     = tags[i];
          rec.last    = (i == keys.size() - 1);
          rec.dropped = overflow;
          sorted_due.insert(sorted_due.size(), rec);
        end
        batches++;
        if (overflow) overflow_batches++;
        keys.delete();
        tags.delete();
        overflow = 1'b0;
      end
    endfunction

    // Compares one accepted result beat with the oldest outstanding one.
    function void match_result(logic [KEY_W-1:0] k, logic [TAG_W-1:0] t, logic l, logic d);
      sorted_rec_t rec;
      results_out++;
      if (sorted_due.size() == 0) begin
        $error("Unexpected result beat: sorted_key %0d sorted_tag %0d", k, t);
        errors++;
        return;
      end
      rec = sorted_due.pop_front();
      if (k !== rec.key) begin
        $error("sorted_key mismatch: expected %0d, got %0d", rec.key, k);
        errors++;
      end
      if (t !== rec.tag) begin
        $error("sorted_tag mismatch: expected %0d, got %0d", rec.tag, t);
        errors++;
      end
      if (l !== rec.last) begin
        $error("final_result mismatch: expected %0b, got %0b", rec.last, l);
        errors++;
      end
      if (d !== rec.dropped) begin
        $error("dropped mismatch: expected %0b, got %0b", rec.dropped, d);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [KEY_W-1:0] in_key;
  logic [TAG_W-1:0] in_tag;
  logic             in_batch_end;
  logic             out_valid;
  logic             out_ready;
  logic [KEY_W-1:0] out_sorted_key;
  logic [TAG_W-1:0] out_sorted_tag;
  logic             out_final_result;
  logic             out_dropped;

  batch_sort_model sorter_model = new();

  // Both sides stop idling for the closing stretch; the long hold fires once.
  bit calm;
  bit random_phase;
  bit hold_done;

  stable_key_sorter_top #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_key          (in_key),
    .in_tag          (in_tag),
    .in_batch_end    (in_batch_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sorted_key  (out_sorted_key),
    .out_sorted_tag  (out_sorted_tag),
    .out_final_result(out_final_result),
    .out_dropped     (out_dropped)
  );

  // 8 ns clock.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Hard limit well beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

  // Every accepted result beat goes straight to the checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sorter_model.match_result(out_sorted_key, out_sorted_tag, out_final_result, out_dropped);
    end
  end

  // Receiver: short random stalls in some stretches, and one long hold-off on the first
  // batch that drains in the random phase, so that the sender is left waiting on in_ready.
  initial begin : receiver
    int cyc;
    bit stall_stretch;
    cyc = 0;
    stall_stretch = 1'b0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 48 == 0) stall_stretch = ($urandom_range(0, 2) != 0);
      if (random_phase && !hold_done && out_valid) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!calm && stall_stretch && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offers one record, with an occasional gap before it, and waits for its beat.
  task automatic offer_record(logic [KEY_W-1:0] k, logic [TAG_W-1:0] t, logic e);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_key       <= k;
    in_tag       <= t;
    in_batch_end <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sorter_model.load_record(k, t, e);
  endtask

  // Keys lean towards the extremes and a narrow range, so that ties are common.
  function automatic logic [KEY_W-1:0] pick_key();
    int mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) return '0;
    if (mode == 1) return KEY_MAX;
    if (mode <= 4) return KEY_W'($urandom_range(0, 7));
    return KEY_W'($urandom());
  endfunction

  // Sends one batch of random records, the last one closing it.
  task automatic send_batch(int len);
    for (int i = 0; i < len; i++) begin
      offer_record(pick_key(), TAG_W'($urandom_range(0, 65535)), i == len - 1);
    end
  endtask

  initial begin : stimulus
    int rand_items;
    int len;
    int waited;
    rand_items   = 0;
    calm         = 1'b0;
    random_phase = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_key       = '0;
    in_tag       = '0;
    in_batch_end = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-record batches at the extremes of both fields.
    offer_record(KEY_MAX, TAG_MAX, 1'b1);
    offer_record('0, '0, 1'b1);
    // Interleaved ties: equal keys must leave in arrival order.
    offer_record(5, 1, 1'b0);
    offer_record(3, 2, 1'b0);
    offer_record(5, 3, 1'b0);
    offer_record(1, 4, 1'b0);
    offer_record(5, 5, 1'b1);
    // Strictly descending keys, each one going to the head.
    offer_record(KEY_MAX, 16'h5555, 1'b0);
    offer_record(KEY_MAX - KEY_W'(1), 16'hAAAA, 1'b0);
    offer_record(1000, 16'h0F0F, 1'b0);
    offer_record(0, 16'hF0F0, 1'b1);
    // Already ascending.
    offer_record(0, 10, 1'b0);
    offer_record(1, 11, 1'b0);
    offer_record(2, 12, 1'b1);
    // All keys equal.
    offer_record(7, 20, 1'b0);
    offer_record(7, 21, 1'b0);
    offer_record(7, 22, 1'b0);
    offer_record(7, 23, 1'b1);

    // Random batches: first exactly full, then a closing record that meets a full
    // store, then several dropped records; mostly short batches after that.
    random_phase = 1'b1;
    while (rand_items < RAND_ITEMS) begin
      if (rand_items == 0) len = CAPACITY;
      else if (rand_items == CAPACITY) len = CAPACITY + 1;
      else if (rand_items == 2 * CAPACITY + 1) len = CAPACITY + 6;
      else if ($urandom_range(0, 9) == 0) len = $urandom_range(CAPACITY - 4, CAPACITY + 6);
      else len = $urandom_range(1, 12);
      calm = (rand_items >= RAND_ITEMS - 80);
      send_batch(len);
      rand_items += len;
    end
    in_valid <= 1'b0;

    // Drain, then give the block time to show any stray beat.
    waited = 0;
    while (sorter_model.sorted_due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (CAPACITY + 20) @(posedge clk);
    if (sorter_model.sorted_due.size() != 0) begin
      $error("%0d sorted beats never arrived", sorter_model.sorted_due.size());
      sorter_model.errors++;
    end

    $display("Run covered %0d records in %0d batches, %0d of them over capacity.",
             sorter_model.records_in, sorter_model.batches, sorter_model.overflow_batches);
    $display("%0d sorted beats were checked field by field.", sorter_model.results_out);
    if (sorter_model.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/sks_pkg.sv
rtl/core/sks_ctrl.sv
rtl/core/sks_datapath.sv
rtl/core/stable_key_sorter_top.sv
tb/tb_stable_key_sorter_top.sv
